>>> sv/tmdc_pkg.sv
// Package for the temperature motor duty controller: register map, action codes,
// microcode word layout and the control program ROM. No dependencies.

package tmdc_pkg;

   // register indexes, byte address is 4 * index
   localparam logic [1:0] REG_MIN_FWD   = 2'd0;
   localparam logic [1:0] REG_MIN_BWD   = 2'd1;
   localparam logic [1:0] REG_START_FWD = 2'd2;
   localparam logic [1:0] REG_START_BWD = 2'd3;

   localparam logic [6:0] MIN_DUTY_RESET   = 7'd30;
   localparam logic [6:0] START_DUTY_RESET = 7'd100;
   localparam logic signed [9:0] SETPOINT_RESET = 10'sd27;
   localparam logic signed [9:0] TEMP_MAX = 10'sd511;
   localparam logic signed [9:0] TEMP_MIN = -10'sd512;

   // setpoint step codes
   localparam logic [1:0] OP_NONE  = 2'd0;
   localparam logic [1:0] OP_RAISE = 2'd1;
   localparam logic [1:0] OP_LOWER = 2'd2;

   // result kinds
   localparam logic [1:0] ACT_STOP = 2'd0;
   localparam logic [1:0] ACT_KICK = 2'd1;
   localparam logic [1:0] ACT_RUN  = 2'd2;

   localparam logic DIR_FWD = 1'b0;
   localparam logic DIR_BWD = 1'b1;

   localparam logic [6:0] DUTY_FULL = 7'd100;

   // datapath widths
   localparam int MUL_A_W = 22;
   localparam int MUL_B_W = 23;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // multiplier constants; floor(x/100) = (x*5243)>>19 for x <= 25500,
   // floor(x/10000) = (x*6871948)>>36 for x <= 2550000
   localparam logic [MUL_B_W-1:0] K_255   = 23'd255;
   localparam logic [MUL_B_W-1:0] K_100   = 23'd100;
   localparam logic [MUL_B_W-1:0] R_100   = 23'd5243;
   localparam logic [MUL_B_W-1:0] R_10K   = 23'd6871948;
   localparam int R_100_SH = 19;
   localparam int R_10K_SH = 36;

   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_LAST = 4'd11;

   typedef enum logic [2:0] {
      A_PROD, A_ST, A_DUTY, A_D, A_MN
   } a_sel_type;

   typedef enum logic [2:0] {
      B_K255, B_K100, B_R100, B_R10K, B_REST
   } b_sel_type;

   typedef enum logic [1:0] {
      EM_NONE, EM_STOP, EM_KICK, EM_RUN
   } emit_type;

   typedef enum logic [1:0] {
      JMP_NONE, JMP_END_IF_SAME, JMP_END
   } jmp_type;

   typedef struct packed {
      a_sel_type a_sel;
      b_sel_type b_sel;
      logic      mul_en;   // load product register
      logic      acc;      // add product register into the new product
      logic      ld_d;
      logic      ld_v;
      logic      eval;     // load direction and duty from the error
      emit_type  emit;
      jmp_type   jmp;
   } ucode_type;

   function automatic logic [6:0] cap100(input logic [6:0] v);
      return (v > DUTY_FULL) ? DUTY_FULL : v;
   endfunction

   // duty = 25 per degree, full at four degrees or more
   function automatic logic [6:0] duty_of(input logic [10:0] mag);
      logic [6:0] r;
      if (mag >= 11'd4) begin
         r = DUTY_FULL;
      end else begin
         case (mag[1:0])
            2'd0: r = 7'd0;
            2'd1: r = 7'd25;
            2'd2: r = 7'd50;
            2'd3: r = 7'd75;
            default: r = 7'd0;
         endcase
      end
      return r;
   endfunction

   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type uc;
      uc = '{a_sel: A_PROD, b_sel: B_K255, mul_en: 1'b0, acc: 1'b0, ld_d: 1'b0,
             ld_v: 1'b0, eval: 1'b0, emit: EM_NONE, jmp: JMP_NONE};
      case (step)
         4'd0: begin                        // evaluate error, leave if nothing moves
            uc.eval = 1'b1;
            uc.jmp  = JMP_END_IF_SAME;
         end
         4'd1: begin                        // stop on reversal, start * 255
            uc.emit = EM_STOP;
            uc.a_sel = A_ST;   uc.b_sel = B_K255; uc.mul_en = 1'b1;
         end
         4'd2: begin                        // / 100
            uc.a_sel = A_PROD; uc.b_sel = B_R100; uc.mul_en = 1'b1;
         end
         4'd3: begin                        // kick from rest, duty * (100 - min)
            uc.emit = EM_KICK;
            uc.a_sel = A_DUTY; uc.b_sel = B_REST; uc.mul_en = 1'b1;
         end
         4'd4: begin                        // / 100
            uc.a_sel = A_PROD; uc.b_sel = B_R100; uc.mul_en = 1'b1;
         end
         4'd5: begin                        // d = min + quotient
            uc.ld_d = 1'b1;
         end
         4'd6: begin                        // d * (100 - min)
            uc.a_sel = A_D;    uc.b_sel = B_REST; uc.mul_en = 1'b1;
         end
         4'd7: begin                        // + 100 * min
            uc.a_sel = A_MN;   uc.b_sel = B_K100; uc.mul_en = 1'b1; uc.acc = 1'b1;
         end
         4'd8: begin                        // * 255
            uc.a_sel = A_PROD; uc.b_sel = B_K255; uc.mul_en = 1'b1;
         end
         4'd9: begin                        // / 10000
            uc.a_sel = A_PROD; uc.b_sel = B_R10K; uc.mul_en = 1'b1;
         end
         4'd10: begin                       // latch v, threshold 255 * min
            uc.ld_v = 1'b1;
            uc.a_sel = A_MN;   uc.b_sel = B_K255; uc.mul_en = 1'b1;
         end
         4'd11: begin                       // running duty, done
            uc.emit = EM_RUN;
            uc.jmp  = JMP_END;
         end
         default: begin
            uc.jmp = JMP_END;
         end
      endcase
      return uc;
   endfunction

endpackage

>>> sv/temperature_motor_duty_control_top.sv
// Temperature motor duty controller, top level: stream ports, APB register file,
// microcoded sequencer and its multiply-add datapath. Depends on tmdc_pkg.
//
// Usage:
//   Each word on the req_ channel is one control tick: measured temperature in
//   req_tdata, setpoint step code in req_tuser. The block answers with zero to
//   three words on the rsp_ channel: a stop before a reversal, a start kick, and
//   the running duty as an 8-bit PWM compare value; rsp_tlast marks the final
//   word of a tick, rsp_tuser carries its kind.
//   A tick is taken while the block is idle, then a 12-step control program runs
//   over one 22x23 multiply-add unit. A tick that changes nothing frees the
//   block after one step. Otherwise the program runs through all 12 steps, and
//   the running duty word is the last word that it emits. The step count is set
//   by the chain of dependent multiplies for the rescale.
//   A step that emits a word holds while the output register is full and
//   rsp_tready is low; req_tready stays low until the program ends.
//   Reset clears setpoint to 27, direction forward, duty 0, and the registers
//   to min duty 30 and start duty 100. Registers sit at byte offsets 0, 4, 8, 12.

module temperature_motor_duty_control_top
   import tmdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [9:0] measured_temp (signed), [15:10] zero
   input  logic [1:0]  req_tuser,   // [1:0] op
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] pwm_compare, [8] motor_direction, [15:9] zero
   output logic [1:0]  rsp_tuser,   // [1:0] action_kind
   output logic        rsp_tlast,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // registers
   logic                     busy_ff, busy_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic signed [9:0]        meas_ff, meas_in;
   logic signed [9:0]        sp_ff, sp_in;
   logic                     dir_ff, dir_in;
   logic [6:0]               duty_ff, duty_in;
   logic                     cur_dir_ff, cur_dir_in;
   logic [6:0]               cur_duty_ff, cur_duty_in;
   logic [6:0]               d_ff, d_in;
   logic [7:0]               v_ff, v_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic [6:0]               cfg_min_ff [2];
   logic [6:0]               cfg_start_ff [2];
   logic [6:0]               cfg_min_in [2];
   logic [6:0]               cfg_start_in [2];
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [7:0]               rsp_pwm_ff, rsp_pwm_in;
   logic                     rsp_dir_ff, rsp_dir_in;
   logic [1:0]               rsp_kind_ff, rsp_kind_in;
   logic                     rsp_last_ff, rsp_last_in;

   // combinational
   ucode_type                uc;
   logic signed [10:0]       err;
   logic                     eval_dir;
   logic [10:0]              mag;
   logic [6:0]               eval_duty;
   logic                     same;
   logic [6:0]               mn, st, rest;
   logic [MUL_A_W-1:0]       mul_a;
   logic [MUL_B_W-1:0]       mul_b;
   logic [PROD_W-1:0]        addend;
   logic                     emit_want, out_free, advance;
   logic [14:0]              v_x100;
   logic [7:0]               run_pwm;
   logic                     req_fire, cfg_wr;

   assign req_tready = !busy_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_paddr[3:2])
         REG_MIN_FWD:   csr_prdata = {25'd0, cfg_min_ff[DIR_FWD]};
         REG_MIN_BWD:   csr_prdata = {25'd0, cfg_min_ff[DIR_BWD]};
         REG_START_FWD: csr_prdata = {25'd0, cfg_start_ff[DIR_FWD]};
         REG_START_BWD: csr_prdata = {25'd0, cfg_start_ff[DIR_BWD]};
         default:       csr_prdata = 32'd0;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_dir_ff, rsp_pwm_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // error and direction
   assign err       = 11'(meas_ff) - 11'(sp_ff);
   assign eval_dir  = err[10] || (err == 11'sd0);
   assign mag       = eval_dir ? 11'(-err) : 11'(err);
   assign eval_duty = duty_of(mag);
   assign same      = (eval_dir == cur_dir_ff) && (eval_duty == cur_duty_ff);

   assign mn   = cap100(cfg_min_ff[dir_ff]);
   assign st   = cap100(cfg_start_ff[dir_ff]);
   assign rest = DUTY_FULL - mn;

   assign uc = ucode_rom(step_ff);

   always_comb begin
      case (uc.a_sel)
         A_PROD:  mul_a = prod_ff[MUL_A_W-1:0];
         A_ST:    mul_a = MUL_A_W'(st);
         A_DUTY:  mul_a = MUL_A_W'(duty_ff);
         A_D:     mul_a = MUL_A_W'(d_ff);
         A_MN:    mul_a = MUL_A_W'(mn);
         default: mul_a = '0;
      endcase
      case (uc.b_sel)
         B_K255:  mul_b = K_255;
         B_K100:  mul_b = K_100;
         B_R100:  mul_b = R_100;
         B_R10K:  mul_b = R_10K;
         B_REST:  mul_b = MUL_B_W'(rest);
         default: mul_b = '0;
      endcase
      addend = uc.acc ? prod_ff : '0;
   end

   always_comb begin
      case (uc.emit)
         EM_STOP: emit_want = (dir_ff != cur_dir_ff);
         EM_KICK: emit_want = (cur_duty_ff == 7'd0) && (duty_ff != 7'd0);
         EM_RUN:  emit_want = 1'b1;
         default: emit_want = 1'b0;
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign advance  = busy_ff && !(emit_want && !out_free);

   // cut to zero at or below the minimum duty
   assign v_x100  = {1'b0, v_ff, 6'd0} + {2'd0, v_ff, 5'd0} + {5'd0, v_ff, 2'd0};
   assign run_pwm = (v_x100 <= prod_ff[14:0]) ? 8'd0 : v_ff;

   always_comb begin
      busy_in      = busy_ff;
      step_in      = step_ff;
      meas_in      = meas_ff;
      sp_in        = sp_ff;
      dir_in       = dir_ff;
      duty_in      = duty_ff;
      cur_dir_in   = cur_dir_ff;
      cur_duty_in  = cur_duty_ff;
      d_in         = d_ff;
      v_in         = v_ff;
      prod_in      = prod_ff;
      cfg_min_in   = cfg_min_ff;
      cfg_start_in = cfg_start_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_pwm_in   = rsp_pwm_ff;
      rsp_dir_in   = rsp_dir_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;

      if (cfg_wr) begin
         case (csr_paddr[3:2])
            REG_MIN_FWD:   cfg_min_in[DIR_FWD]   = csr_pwdata[6:0];
            REG_MIN_BWD:   cfg_min_in[DIR_BWD]   = csr_pwdata[6:0];
            REG_START_FWD: cfg_start_in[DIR_FWD] = csr_pwdata[6:0];
            REG_START_BWD: cfg_start_in[DIR_BWD] = csr_pwdata[6:0];
            default: ;
         endcase
      end

      if (req_fire) begin
         meas_in = req_tdata[9:0];
         if (req_tuser == OP_RAISE && sp_ff != TEMP_MAX) begin
            sp_in = sp_ff + 10'sd1;
         end else if (req_tuser == OP_LOWER && sp_ff != TEMP_MIN) begin
            sp_in = sp_ff - 10'sd1;
         end
         busy_in = 1'b1;
         step_in = '0;
      end

      if (advance) begin
         if (uc.eval) begin
            dir_in  = eval_dir;
            duty_in = eval_duty;
         end
         if (uc.mul_en) begin
            prod_in = PROD_W'(mul_a * mul_b) + addend;
         end
         if (uc.ld_d) begin
            d_in = (duty_ff == 7'd0) ? 7'd0 : mn + prod_ff[R_100_SH+6:R_100_SH];
         end
         if (uc.ld_v) begin
            v_in = (prod_ff[R_10K_SH+8] == 1'b1) ? 8'd255 : prod_ff[R_10K_SH+7:R_10K_SH];
         end
         if (emit_want) begin
            rsp_valid_in = 1'b1;
            case (uc.emit)
               EM_STOP: begin
                  rsp_pwm_in  = 8'd0;
                  rsp_dir_in  = cur_dir_ff;
                  rsp_kind_in = ACT_STOP;
                  rsp_last_in = 1'b0;
                  cur_dir_in  = dir_ff;
                  cur_duty_in = 7'd0;
               end
               EM_KICK: begin
                  rsp_pwm_in  = prod_ff[R_100_SH+7:R_100_SH];
                  rsp_dir_in  = dir_ff;
                  rsp_kind_in = ACT_KICK;
                  rsp_last_in = 1'b0;
               end
               default: begin
                  rsp_pwm_in  = run_pwm;
                  rsp_dir_in  = dir_ff;
                  rsp_kind_in = ACT_RUN;
                  rsp_last_in = 1'b1;
                  cur_duty_in = duty_ff;
               end
            endcase
         end
         // step counter and jumps
         if ((uc.jmp == JMP_END) || (uc.jmp == JMP_END_IF_SAME && same) ||
             step_ff == STEP_LAST) begin
            busy_in = 1'b0;
            step_in = '0;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff         <= 1'b0;
         step_ff         <= '0;
         sp_ff           <= SETPOINT_RESET;
         cur_dir_ff      <= DIR_FWD;
         cur_duty_ff     <= 7'd0;
         cfg_min_ff[0]   <= MIN_DUTY_RESET;
         cfg_min_ff[1]   <= MIN_DUTY_RESET;
         cfg_start_ff[0] <= START_DUTY_RESET;
         cfg_start_ff[1] <= START_DUTY_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         busy_ff         <= busy_in;
         step_ff         <= step_in;
         sp_ff           <= sp_in;
         cur_dir_ff      <= cur_dir_in;
         cur_duty_ff     <= cur_duty_in;
         cfg_min_ff      <= cfg_min_in;
         cfg_start_ff    <= cfg_start_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      meas_ff     <= meas_in;
      dir_ff      <= dir_in;
      duty_ff     <= duty_in;
      d_ff        <= d_in;
      v_ff        <= v_in;
      prod_ff     <= prod_in;
      rsp_pwm_ff  <= rsp_pwm_in;
      rsp_dir_ff  <= rsp_dir_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   // a taken tick always starts the program at its first step
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> busy_ff && step_ff == '0)
      else $error("tick taken without restarting the program");

   // only the running duty word closes a tick
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == ACT_RUN)))
      else $error("tlast does not match running duty word");

   // a stop word is zero and carries the direction left behind
   a_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ACT_STOP |-> rsp_tdata[7:0] == 8'd0 &&
         rsp_tdata[8] != cur_dir_ff)
      else $error("stop word inconsistent with direction state");

   // kept duty moves only while the program runs
   a_duty_hold: assert property (@(posedge clock) disable iff (reset)
      !busy_ff && !(req_tvalid && req_tready) |=> $stable(cur_duty_ff))
      else $error("duty state changed while idle");

endmodule

>>> test/tb_top.sv
// Testbench for temperature_motor_duty_control_top: drives control ticks, predicts the
// PWM words in a local copy of the controller and checks each rsp_ word in order.
// Depends on tmdc_pkg and the top level RTL.

module tb_top;
   import tmdc_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int IDLE_PCT = 21;
   localparam int CYCLE_LIMIT = 500000;
   localparam int SETTLE_CYCLES = 20;

   typedef struct packed {
      logic signed [9:0] temp;
      logic [1:0]        op;
   } tick_word_type;

   typedef struct packed {
      logic [7:0] pwm;
      logic       dir;
      logic [1:0] kind;
      logic       last;
   } duty_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   temperature_motor_duty_control_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   tick_word_type ticks_pending[$];
   duty_word_type duty_words_due[$];
   int         mismatches = 0;
   int         cycles = 0;
   bit         calm = 1'b0;     // no idling on either side while set
   int         sp_plan = 27;    // setpoint as the queued ticks will leave it

   // controller copy
   logic [6:0]        min_pct[2] = '{MIN_DUTY_RESET, MIN_DUTY_RESET};
   logic [6:0]        start_pct[2] = '{START_DUTY_RESET, START_DUTY_RESET};
   logic signed [9:0] sp_now = SETPOINT_RESET;
   logic              dir_now = DIR_FWD;
   int                duty_now = 0;

   task automatic forecast_tick(input logic signed [9:0] meas, input logic [1:0] op);
      int         err;
      int         mag;
      int         duty;
      int         mn;
      int         st;
      int         d;
      int         v;
      logic       new_dir;
      if (op == OP_RAISE && sp_now < TEMP_MAX) begin
         sp_now = sp_now + 10'sd1;
      end else if (op == OP_LOWER && sp_now > TEMP_MIN) begin
         sp_now = sp_now - 10'sd1;
      end
      err = int'(meas) - int'(sp_now);
      if (err <= 0) begin
         new_dir = DIR_BWD;
         mag = -err;
      end else begin
         new_dir = DIR_FWD;
         mag = err;
      end
      duty = (mag >= 4) ? 100 : 25 * mag;
      if (new_dir == dir_now && duty == duty_now) return;
      if (new_dir != dir_now) begin
         duty_words_due.push_back('{pwm: 8'd0, dir: dir_now, kind: ACT_STOP, last: 1'b0});
         duty_now = 0;
         dir_now = new_dir;
      end
      mn = (min_pct[new_dir] > 7'd100) ? 100 : int'(min_pct[new_dir]);
      st = (start_pct[new_dir] > 7'd100) ? 100 : int'(start_pct[new_dir]);
      if (duty_now == 0 && duty != 0) begin
         duty_words_due.push_back('{pwm: 8'((st * 255) / 100), dir: new_dir,
                                    kind: ACT_KICK, last: 1'b0});
      end
      d = 0;
      if (duty != 0) begin
         d = mn + (duty * (100 - mn)) / 100;
         if (d > 100) d = 100;
      end
      v = (255 * (d * (100 - mn) + 100 * mn)) / 10000;
      if (v > 255) v = 255;
      // cut to zero at or below the minimum duty
      if (100 * v <= 255 * mn) v = 0;
      duty_words_due.push_back('{pwm: 8'(v), dir: new_dir, kind: ACT_RUN, last: 1'b1});
      duty_now = duty;
   endtask

   // sender: hold a word until taken, then advance
   always @(posedge clock) begin : sender
      tick_word_type t;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) forecast_tick($signed(req_tdata[9:0]), req_tuser);
         if (!req_tvalid || req_tready) begin
            if (ticks_pending.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
               t = ticks_pending.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {6'd0, t.temp};
               req_tuser <= t.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: random stalls, compare each word with the oldest prediction
   always @(posedge clock) begin : receiver
      duty_word_type got;
      duty_word_type want;
      rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{pwm: rsp_tdata[7:0], dir: rsp_tdata[8], kind: rsp_tuser, last: rsp_tlast};
         if (duty_words_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word: %p", got);
         end else begin
            want = duty_words_due.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("word mismatch: expected %p, actual %p", want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb_top NOT OK");
         $finish;
      end
   end

   function automatic int clamp_temp(input int t);
      return (t > 511) ? 511 : ((t < -512) ? -512 : t);
   endfunction

   function automatic int pick_pct();
      return ($urandom_range(9) == 0) ? $urandom_range(127, 101) : $urandom_range(100);
   endfunction

   task automatic queue_tick(input int meas, input logic [1:0] op);
      if (op == OP_RAISE && sp_plan < 511) sp_plan++;
      else if (op == OP_LOWER && sp_plan > -512) sp_plan--;
      ticks_pending.push_back('{temp: 10'(meas), op: op});
   endtask

   task automatic queue_random_ticks(input int count);
      int         r;
      logic [1:0] op;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         op = (r < 55) ? OP_NONE : (r < 75) ? OP_RAISE : (r < 95) ? OP_LOWER : OP_UNUSED;
         if ($urandom_range(99) < 80) begin
            // near the setpoint it will have after this step
            r = sp_plan + ((op == OP_RAISE) ? 1 : (op == OP_LOWER) ? -1 : 0);
            queue_tick(clamp_temp(r + $urandom_range(12) - 6), op);
         end else begin
            queue_tick($signed(10'($urandom)), op);
         end
      end
   endtask

   // wait until every word is sent and every prediction matched, then let the block settle
   task automatic drain();
      do @(negedge clock);
      while (ticks_pending.size() != 0 || req_tvalid || duty_words_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input int val);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {$urandom} & 32'hFFFF_FF80 | 32'(val & 8'h7F);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_MIN_FWD:   min_pct[DIR_FWD] = 7'(val);
         REG_MIN_BWD:   min_pct[DIR_BWD] = 7'(val);
         REG_START_FWD: start_pct[DIR_FWD] = 7'(val);
         default:       start_pct[DIR_BWD] = 7'(val);
      endcase
   endtask

   task automatic set_limits(input int mf, input int mb, input int sf, input int sb);
      write_reg(REG_MIN_FWD, mf);
      write_reg(REG_MIN_BWD, mb);
      write_reg(REG_START_FWD, sf);
      write_reg(REG_START_BWD, sb);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset register values
      queue_tick(27, OP_NONE);       // zero error: reversal to backward at rest
      queue_tick(28, OP_NONE);       // reversal with kick
      queue_tick(29, OP_NONE);
      queue_tick(29, OP_NONE);       // nothing moves
      queue_tick(30, OP_NONE);
      queue_tick(31, OP_NONE);
      queue_tick(511, OP_NONE);      // already full
      queue_tick(-512, OP_NONE);
      queue_tick(26, OP_NONE);
      queue_tick(27, OP_RAISE);
      queue_tick(28, OP_LOWER);
      queue_tick(28, OP_UNUSED);
      queue_tick(27, OP_NONE);       // reversal to zero duty, no kick
      queue_tick(23, OP_NONE);
      queue_tick(27, OP_NONE);
      queue_tick(28, OP_RAISE);
      queue_tick(32, OP_NONE);
      queue_tick(-512, OP_LOWER);
      queue_tick(511, OP_RAISE);
      queue_tick(30, OP_NONE);
      queue_tick(-1, OP_NONE);
      drain();

      set_limits(0, 0, 0, 0);
      queue_random_ticks(40);
      drain();

      set_limits(100, 100, 100, 100);
      calm = 1'b1;
      queue_random_ticks(40);
      drain();
      calm = 1'b0;

      set_limits(127, 127, 127, 127);
      queue_random_ticks(40);
      drain();

      for (int p = 0; p < 3; p++) begin
         set_limits(pick_pct(), pick_pct(), pick_pct(), pick_pct());
         queue_random_ticks(40);
         drain();
      end

      // sweep the setpoint up and back down
      set_limits(pick_pct(), pick_pct(), pick_pct(), pick_pct());
      for (int s = 0; s < 6; s++) queue_tick(clamp_temp(sp_plan + 2), OP_RAISE);
      for (int s = 0; s < 6; s++) queue_tick(clamp_temp(sp_plan - 2), OP_LOWER);
      drain();

      if (mismatches == 0 && duty_words_due.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
